/* src/hri_pkg.sv */
// Shared types, constants and the prime table for the Halton radical inverse block.
package hri_pkg;

    // Port field widths
    localparam int SEL_W   = 6;
    localparam int INDEX_W = 31;
    localparam int FRAC_W  = 32;

    // Width of a prime and of a base-p digit (largest prime is 283)
    localparam int PRIME_W = 9;

    // Parameter defaults
    localparam int PRIME_COUNT_DEF   = 61;
    localparam int INDEX_BITS_DEF    = 31;
    localparam int FRACTION_BITS_DEF = 32;

    // The first 61 primes
    localparam logic [PRIME_W-1:0] PRIME_TABLE [61] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,  9'd29,
        9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,  9'd61,  9'd67,  9'd71,
        9'd73,  9'd79,  9'd83,  9'd89,  9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113,
        9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229,
        9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269, 9'd271, 9'd277, 9'd281,
        9'd283
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic ext_start;
        logic horn_start;
        logic div_step;
        logic push;
        logic out_load;
    } hri_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic n_zero;
        logic stack_empty;
        logic div_last;
    } hri_sts_t;

endpackage

/* src/hri_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface hri_in_if;
    logic                            valid;
    logic                            ready;
    logic [hri_pkg::SEL_W-1:0]       base_select;
    logic [hri_pkg::INDEX_W-1:0]     sequence_index;

    modport source (output valid, output base_select, output sequence_index, input ready);
    modport sink   (input valid, input base_select, input sequence_index, output ready);
endinterface

interface hri_out_if;
    logic                            valid;
    logic                            ready;
    logic [hri_pkg::FRAC_W-1:0]      fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

/* src/hri_ctrl.sv */
// Controller state machine: sequences digit extraction, Horner steps and result hand-off.
module hri_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hri_pkg::hri_cmd_t cmd,
    input  hri_pkg::hri_sts_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_EXT    = 3'd2;
    localparam logic [2:0] S_PUSH   = 3'd3;
    localparam logic [2:0] S_HCHECK = 3'd4;
    localparam logic [2:0] S_HORN   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.n_zero)
                begin
                    state_next = S_HCHECK;
                end
                else
                begin
                    cmd.ext_start = 1'b1;
                    state_next    = S_EXT;
                end
            end
            S_EXT:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_CHECK;
            end
            S_HCHECK:
            begin
                if (sts.stack_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.horn_start = 1'b1;
                    state_next     = S_HORN;
                end
            end
            S_HORN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_HCHECK;
                end
            end
            S_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // a finished item is presented in the next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented after load");

    // a Horner step is only started with a digit on the stack
    a_horn_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.horn_start |-> !sts.stack_empty)
        else $error("Horner step started on empty stack");
`endif

endmodule

/* src/hri_dpath.sv */
// Datapath: shared restoring divider by the selected prime, digit stack and result register.
module hri_dpath
#(
    parameter int PRIME_COUNT   = hri_pkg::PRIME_COUNT_DEF,
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [hri_pkg::SEL_W-1:0]    base_select,
    input  logic [hri_pkg::INDEX_W-1:0]  sequence_index,
    output logic [hri_pkg::FRAC_W-1:0]   fraction,
    input  hri_pkg::hri_cmd_t            cmd,
    output hri_pkg::hri_sts_t            sts
);

    localparam int PW       = hri_pkg::PRIME_W;
    localparam int SP_W     = $clog2(INDEX_BITS);
    localparam int CNT_W    = $clog2(INDEX_BITS + 1);
    localparam int STEP_MAX = (FRACTION_BITS > INDEX_BITS) ? FRACTION_BITS : INDEX_BITS;
    localparam int STEP_W   = $clog2(STEP_MAX);

    localparam logic [hri_pkg::SEL_W-1:0] SEL_LAST = hri_pkg::SEL_W'(PRIME_COUNT - 1);
    localparam logic [STEP_W-1:0] EXT_LAST  = STEP_W'(INDEX_BITS - 1);
    localparam logic [STEP_W-1:0] HORN_LAST = STEP_W'(FRACTION_BITS - 1);
    localparam logic [CNT_W-1:0]  STACK_DEPTH = CNT_W'(INDEX_BITS);

    // Control-like registers
    logic [CNT_W-1:0]         cnt_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     mode_reg;   // 0: digit extraction, 1: Horner step

    // Payload registers
    logic [PW-1:0]            prime_reg;
    logic [PW-1:0]            rem_reg;
    logic [INDEX_BITS-1:0]    n_reg;
    logic [FRACTION_BITS-1:0] h_reg;
    logic [hri_pkg::FRAC_W-1:0] fraction_reg;
    logic [PW-1:0]            stack_reg [INDEX_BITS];

    logic [hri_pkg::SEL_W-1:0] sel_sat;
    logic                     bit_in;
    logic [PW:0]              trial;
    logic                     ge;
    logic [PW-1:0]            rem_next;
    logic [PW-1:0]            digit;
    logic [CNT_W-1:0]         cnt_dec;

    // Selector saturates to the last table entry
    assign sel_sat = (base_select > SEL_LAST) ? SEL_LAST : base_select;

    // One restoring division step: shift in a dividend bit, subtract p if it fits
    assign bit_in   = mode_reg ? h_reg[FRACTION_BITS-1] : n_reg[INDEX_BITS-1];
    assign trial    = {rem_reg, bit_in};
    assign ge       = (trial >= {1'b0, prime_reg});
    assign rem_next = ge ? PW'(trial - {1'b0, prime_reg}) : trial[PW-1:0];

    // Reflected digit: nonzero d becomes p - d
    assign digit   = (rem_reg == '0) ? '0 : (prime_reg - rem_reg);
    assign cnt_dec = cnt_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            step_reg <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.push)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.horn_start)
            begin
                cnt_reg <= cnt_dec;
            end

            if (cmd.ext_start || cmd.horn_start)
            begin
                step_reg <= '0;
                mode_reg <= cmd.horn_start;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Operand, quotient and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            prime_reg <= hri_pkg::PRIME_TABLE[sel_sat];
            n_reg     <= sequence_index[INDEX_BITS-1:0];
            h_reg     <= '0;
        end
        if (cmd.ext_start)
        begin
            rem_reg <= '0;
        end
        else if (cmd.horn_start)
        begin
            rem_reg <= stack_reg[cnt_dec[SP_W-1:0]];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            if (mode_reg)
            begin
                h_reg <= {h_reg[FRACTION_BITS-2:0], ge};
            end
            else
            begin
                n_reg <= {n_reg[INDEX_BITS-2:0], ge};
            end
        end
        if (cmd.push)
        begin
            stack_reg[cnt_reg[SP_W-1:0]] <= digit;
        end
        if (cmd.out_load)
        begin
            fraction_reg <= hri_pkg::FRAC_W'(h_reg);
        end
    end

    assign sts.n_zero      = (n_reg == '0);
    assign sts.stack_empty = (cnt_reg == '0);
    assign sts.div_last    = (step_reg == (mode_reg ? HORN_LAST : EXT_LAST));
    assign fraction        = fraction_reg;

`ifndef ASSERT_OFF
    // the digit stack never overflows
    a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cnt_reg < STACK_DEPTH))
        else $error("digit stack overflow");

    // the partial remainder always stays below the divisor
    a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < prime_reg))
        else $error("remainder not below prime");
`endif

endmodule

/* src/halton_radical_inverse.sv */
// Halton radical inverse with reflected digits, exact Q0.32 result.
//
// Input channel item_in carries base_select (prime table index, saturating at the
// last entry) and sequence_index. Output channel result_out carries fraction,
// the radical inverse as an unsigned Q0.32 value. Both use valid/ready; an item
// moves when valid and ready are high at a rising clock edge.
// One item is worked on at a time. A single restoring divider by the selected
// prime produces one quotient bit per cycle: it first splits the index into D
// base-p digits (check, division, push per digit), then folds them back by
// Horner steps (check and division per digit). Index zero has no digits and
// goes straight to the result. item_in.ready rises with the result, so the
// next item is taken only once the last one is done. D is at most 31 in
// base 2 and 4 in base 283.
// The finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following result is held
// internally until the output register frees.
// Reset (rst_n, asynchronous, active low) returns the block to idle with no
// result pending.
module halton_radical_inverse
#(
    parameter int PRIME_COUNT   = hri_pkg::PRIME_COUNT_DEF,
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    hri_in_if.sink    item_in,
    hri_out_if.source result_out
);

    hri_pkg::hri_cmd_t cmd;
    hri_pkg::hri_sts_t sts;

    // Sequencer
    hri_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Divider, digit stack and result register
    hri_dpath
    #(
        .PRIME_COUNT   (PRIME_COUNT),
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .base_select    (item_in.base_select),
        .sequence_index (item_in.sequence_index),
        .fraction       (result_out.fraction),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* tb/tb_halton_radical_inverse.sv */
// Self-checking testbench for the scrambled Halton radical inverse block.
`timescale 1ns / 1ps

module tb_halton_radical_inverse;

    localparam int SEL_W           = hri_pkg::SEL_W;
    localparam int INDEX_W         = hri_pkg::INDEX_W;
    localparam int FRAC_W          = hri_pkg::FRAC_W;
    localparam int PRIME_COUNT_DEF = hri_pkg::PRIME_COUNT_DEF;

    localparam longint unsigned INDEX_MAX = (64'd1 << INDEX_W) - 1;
    localparam int              MAX_LATENCY = 2100;

    typedef struct {
        logic [SEL_W-1:0]   sel;
        logic [INDEX_W-1:0] idx;
        bit                 drain;   // hold until all results are back
        bit                 steady;  // no idling on either side
    } stim_t;

    logic clk;
    logic rst_n;

    hri_in_if  item_if ();
    hri_out_if res_if ();

    stim_t                 pending_items [$];
    logic [FRAC_W-1:0]     expected_fractions [$];
    int unsigned           mismatches;
    bit                    steady_phase;

    halton_radical_inverse i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // k-th prime by trial division, k counted from zero
    function automatic longint unsigned kth_prime(int unsigned k);
        longint unsigned cand;
        longint unsigned f;
        int unsigned     found;
        bit              is_p;
        cand  = 1;
        found = 0;
        do
        begin
            cand++;
            is_p = 1'b1;
            for (f = 2; f * f <= cand; f++)
                if (cand % f == 0)
                    is_p = 1'b0;
            if (is_p)
                found++;
        end
        while (found <= k);
        return cand;
    endfunction

    // Radix for a selector, saturating at the last table entry
    function automatic longint unsigned radix_of(logic [SEL_W-1:0] sel);
        int unsigned s;
        s = (sel > PRIME_COUNT_DEF - 1) ? PRIME_COUNT_DEF - 1 : int'(sel);
        return kth_prime(s);
    endfunction

    // Reflected-digit radical inverse, exact, truncated to Q0.32
    function automatic logic [FRAC_W-1:0] reflected_inverse(logic [SEL_W-1:0]   sel,
                                                            logic [INDEX_W-1:0] idx);
        longint unsigned p;
        longint unsigned n;
        longint unsigned d;
        longint unsigned acc;
        longint unsigned digits [$];
        p   = radix_of(sel);
        n   = idx;
        acc = 0;
        // split into digits, least significant first; nonzero d maps to p - d
        while (n != 0)
        begin
            d      = n % p;
            digits = {digits, ((d == 0) ? d : p - d)};
            n      = n / p;
        end
        // fold back from the most significant digit
        while (digits.size() != 0)
            acc = ((digits.pop_back() << FRAC_W) + acc) / p;
        return acc[FRAC_W-1:0];
    endfunction

    task automatic add_item(input logic [SEL_W-1:0] sel, input longint unsigned idx,
                            input bit drain = 1'b0, input bit steady = 1'b0);
        stim_t s;
        s.sel    = sel;
        s.idx    = idx[INDEX_W-1:0];
        s.drain  = drain;
        s.steady = steady;
        pending_items = {pending_items, s};
    endtask

    // Known values on every block input from time zero
    initial
    begin
        item_if.valid          = 1'b0;
        item_if.base_select    = '0;
        item_if.sequence_index = '0;
        res_if.ready           = 1'b0;
        steady_phase           = 1'b0;
        mismatches             = 0;
    end

    // Driver: presents queued items on the input channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
        end
        else if (!(item_if.valid && !item_if.ready))
        begin
            if (pending_items.size() != 0 &&
                !(pending_items[0].drain &&
                  ((item_if.valid && item_if.ready) || expected_fractions.size() != 0)) &&
                !(!pending_items[0].steady && $urandom_range(99) < 17))
            begin
                item_if.valid          <= 1'b1;
                item_if.base_select    <= pending_items[0].sel;
                item_if.sequence_index <= pending_items[0].idx;
                steady_phase           <= pending_items[0].steady;
                void'(pending_items.pop_front());
            end
            else
            begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts on each accepted item, stalls the receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_fractions.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected fraction, expected none, actual %h",
                             $time, res_if.fraction);
                end
                else
                begin
                    if (res_if.fraction !== expected_fractions[0])
                    begin
                        mismatches++;
                        $display("%0t: fraction mismatch, expected %h, actual %h",
                                 $time, expected_fractions[0], res_if.fraction);
                    end
                    void'(expected_fractions.pop_front());
                end
            end
            if (item_if.valid && item_if.ready)
                expected_fractions = {expected_fractions,
                                      reflected_inverse(item_if.base_select,
                                                        item_if.sequence_index)};
            res_if.ready <= steady_phase || ($urandom_range(99) >= 17);
        end
    end

    // Stimulus and end of run
    initial
    begin
        longint unsigned p;
        longint unsigned pw;
        longint unsigned idx;
        int unsigned     k;
        int unsigned     pick;
        logic [SEL_W-1:0] sel;

        rst_n = 1'b0;

        // directed: field extremes, saturation, index zero, digit patterns
        add_item(6'd0,  0);
        add_item(6'd0,  1);
        add_item(6'd0,  INDEX_MAX);
        add_item(6'd0,  64'd1 << 30);
        add_item(6'd60, INDEX_MAX);
        add_item(6'd60, 0);
        add_item(6'd61, 12345);
        add_item(6'd62, INDEX_MAX);
        add_item(6'd63, INDEX_MAX);
        add_item(6'd63, 0);
        add_item(6'd63, 22665187);      // 283^3
        add_item(6'd60, 22665186);      // 283^3 - 1, all top digits
        add_item(6'd1,  1162261467);    // 3^19
        add_item(6'd1,  1162261466);    // 3^19 - 1
        add_item(6'd2,  1220703125);    // 5^13
        add_item(6'd30, 127);
        add_item(6'd30, 126);
        add_item(6'd32, 64'h2AAA_AAAA);
        add_item(6'd21, 64'h5555_5555);
        add_item(6'd42, 1);
        add_item(6'd59, 281 * 281 + 1);
        add_item(6'd15, 53);

        // random part, with a stretch of no idling and two full drains
        for (int i = 0; i < 1700; i++)
        begin
            sel  = SEL_W'($urandom_range(0, 63));
            pick = $urandom_range(99);
            if (pick < 55)
                idx = $urandom() & INDEX_MAX;
            else if (pick < 75)
                idx = $urandom_range(0, 300);
            else if (pick < 92)
            begin
                // around a power of the radix, where digits roll over
                p  = radix_of(sel);
                k  = $urandom_range(1, 31);
                pw = 1;
                while (k != 0 && pw * p <= INDEX_MAX)
                begin
                    pw = pw * p;
                    k--;
                end
                idx = (pw + $urandom_range(0, 2) - 1) & INDEX_MAX;
            end
            else if (pick < 96)
                idx = 0;
            else
                idx = INDEX_MAX;
            add_item(sel, idx, (i == 0 || i == 900), (i >= 300 && i < 600));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_if.valid)
            @(posedge clk);
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (MAX_LATENCY) @(posedge clk);

        if (mismatches == 0 && expected_fractions.size() == 0)
            $display("tb_halton_radical_inverse: clean");
        else
            $display("tb_halton_radical_inverse: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200_000_000;
        $display("tb_halton_radical_inverse: errors");
        $finish;
    end

endmodule
